// ===== rtl/spfa_pkg.sv =====
// Shared types and constants of the SPH pressure force accumulator.
package spfa_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE = 2'd1;

	localparam logic [31:0] RADIUS_RESET     = 32'd1048576;
	localparam logic [47:0] GRAD_SCALE_RESET = 48'd80110000;

	localparam logic CMD_CENTER   = 1'b0;
	localparam logic CMD_NEIGHBOR = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pressure;
		logic [31:0]        density;
		logic [31:0]        mass;
		logic               is_self;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
	} out_item_t;

	typedef struct packed {
		logic [31:0] radius;
		logic [47:0] grad_scale;
	} cfg_t;

	// One classified transaction as it waits between front and back.
	typedef struct packed {
		logic        center;
		logic        skip;
		logic        last;
		logic        dx_neg;
		logic        dy_neg;
		logic        p_neg;
		logic [31:0] adx;
		logic [31:0] ady;
		logic [31:0] pmag;
		logic [31:0] density;
		logic [31:0] mass;
	} q_entry_t;

endpackage

// ===== rtl/sph_pressure_force_accumulate.sv =====
// Top level of the SPH pressure force accumulator: configuration registers and datapath.
//
// Usage: in_data carries one transaction per handshake on in_valid/in_ready.
// A center transaction loads position and pressure of the particle and clears
// the force sum; each neighbor transaction adds its spiky kernel pressure term
// and, closer than one unit, a soft repulsion. On a neighbor marked last the
// sum times 8, saturated to Q16.16, appears on out_data with out_valid.
// cfg_index/cfg_data with cfg_valid write the smoothing radius (index 0) or
// the gradient scale (index 1); cfg_ready is always high.
// Back end: a center or a skipped neighbor only passes the IDLE and DONE states;
// a full neighbor runs the bit-serial square root, three restoring divisions
// and up to ten 64x64 products, each formed from 32x32 partial products on one
// shared multiplier and scaled back to Q16.16 for the default FRAC_BITS.
// A two-entry queue behind the front end keeps taking transactions while the
// back end works, until it is full. If the receiver stalls, the result waits in the output
// register and the back end holds at the next result until it is taken.
// Reset clears the center, the sums and the queue and loads the register
// defaults; no result is pending after reset.
module sph_pressure_force_accumulate import spfa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [47:0]          cfg_data
);

	cfg_t cfg_q;
	logic q_push, q_full, q_pop, q_nonempty;
	q_entry_t q_din, q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius     <= RADIUS_RESET;
			cfg_q.grad_scale <= GRAD_SCALE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIUS:     cfg_q.radius     <= cfg_data[31:0];
				REG_GRAD_SCALE: cfg_q.grad_scale <= cfg_data;
				default:        ;
			endcase
		end
	end

	spfa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.radius   (cfg_q.radius),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_din    (q_din)
	);

	spfa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      (q_din),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.dout     (q_dout)
	);

	spfa_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.q_dout     (q_dout),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/spfa_front.sv =====
// Front end: accepts input transactions, keeps the center particle and classifies neighbors.
module spfa_front import spfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic [31:0] radius,
	input  logic     q_full,
	output logic     q_push,
	output q_entry_t q_din
);

	logic signed [31:0] cx_q, cy_q, cp_q;
	logic signed [32:0] dx, dy, psum;
	logic [32:0] adx, ady, pabs;
	logic accept;

	assign in_ready = ~q_full;
	assign accept   = in_valid & ~q_full;
	assign q_push   = accept;

	always_comb begin
		dx   = {cx_q[31], cx_q} - {in_data.pos_x[31], in_data.pos_x};
		dy   = {cy_q[31], cy_q} - {in_data.pos_y[31], in_data.pos_y};
		psum = {cp_q[31], cp_q} + {in_data.pressure[31], in_data.pressure};
		adx  = dx[32] ? 33'(-dx) : 33'(dx);
		ady  = dy[32] ? 33'(-dy) : 33'(dy);
		pabs = psum[32] ? 33'(-psum) : 33'(psum);
		q_din.center  = (in_data.cmd == CMD_CENTER);
		// Neighbors outside the square of side 2h can never fall inside the kernel.
		q_din.skip    = in_data.is_self | (adx > {1'b0, radius}) | (ady > {1'b0, radius});
		q_din.last    = in_data.last;
		q_din.dx_neg  = dx[32];
		q_din.dy_neg  = dy[32];
		q_din.p_neg   = psum[32];
		q_din.adx     = adx[31:0];
		q_din.ady     = ady[31:0];
		q_din.pmag    = pabs[32:1];
		q_din.density = in_data.density;
		q_din.mass    = in_data.mass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cp_q <= '0;
		end else if (accept && in_data.cmd == CMD_CENTER) begin
			cx_q <= in_data.pos_x;
			cy_q <= in_data.pos_y;
			cp_q <= in_data.pressure;
		end
	end

endmodule

// ===== rtl/spfa_queue.sv =====
// Short queue of classified transactions between front and back.
module spfa_queue import spfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	output logic     full,
	input  logic     pop,
	output logic     nonempty,
	output q_entry_t dout
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	q_entry_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/spfa_back.sv =====
// Back end: sequencer with a shared multiplier, square root and divider that accumulates forces.
module spfa_back import spfa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_nonempty,
	input  q_entry_t  q_dout,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int DIVW = 32 + FRAC_BITS;
	localparam int CW   = $clog2(DIVW);
	localparam logic [32:0] ONE_RAW    = 33'(2 ** FRAC_BITS);
	localparam logic [32:0] EPS_RAW    = 33'((2 ** FRAC_BITS + 50000) / 100000);
	localparam logic [31:0] DFLOOR_RAW = 32'((2 ** FRAC_BITS + 5000) / 10000);
	localparam logic [63:0] MAG_CAP    = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001,
		ST_MUL   = 20'h00002,
		ST_DIV   = 20'h00004,
		ST_SQY   = 20'h00008,
		ST_SQRT0 = 20'h00010,
		ST_SQRT  = 20'h00020,
		ST_CHK   = 20'h00040,
		ST_GRAD  = 20'h00080,
		ST_DIVM  = 20'h00100,
		ST_MA    = 20'h00200,
		ST_MB    = 20'h00400,
		ST_DIVX  = 20'h00800,
		ST_DIVY  = 20'h01000,
		ST_PX    = 20'h02000,
		ST_PY    = 20'h04000,
		ST_PYA   = 20'h08000,
		ST_REP   = 20'h10000,
		ST_RY    = 20'h20000,
		ST_RYA   = 20'h40000,
		ST_DONE  = 20'h80000
	} state_t;

	function automatic logic [63:0] sat_shr(input logic [127:0] p, input int sh);
		logic [127:0] r;
		r = p >> sh;
		return (r[127:63] != '0) ? MAG_CAP : r[63:0];
	endfunction

	function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
			input logic [63:0] mag, input logic neg);
		logic [46:0] m;
		logic signed [48:0] t, s;
		m = (mag > 64'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF : mag[46:0];
		t = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
		s = $signed({acc[47], acc}) + t;
		if (s[48] != s[47]) begin
			return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end
		return s[47:0];
	endfunction

	function automatic logic signed [31:0] emit(input logic signed [47:0] acc);
		logic [50:0] v;
		v = {acc, 3'b000};
		if (v[50:31] != {20{v[50]}}) begin
			return v[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[31:0];
	endfunction

	state_t st_q, ret_q;
	q_entry_t e_q;
	logic [CW-1:0] cnt_q;
	logic [63:0] mul_a_q, mul_b_q, sx_q, grad_q, b_q;
	logic [127:0] prod_q;
	logic [65:0] sq_q;
	logic [35:0] rem_q;
	logic [32:0] root_q;
	logic [DIVW-1:0] div_num_q;
	logic [32:0] div_den_q, div_rem_q;
	logic [FRAC_BITS:0] ux_q, uy_q;
	logic signed [47:0] sum_x_q, sum_y_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [31:0] a_half, b_half;
	logic [63:0] pp;
	logic [127:0] pp_ext;
	logic [35:0] sq_rem, sq_trial;
	logic [33:0] div_r;
	logic div_ge;
	logic [31:0] dens;
	logic [63:0] rep_val;
	logic [31:0] hr;
	logic emit_now;

	assign q_pop     = (st_q == ST_IDLE) && q_nonempty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign emit_now  = (st_q == ST_DONE) && !e_q.center && e_q.last &&
		(!out_valid_q || out_ready);

	always_comb begin
		a_half = cnt_q[0] ? mul_a_q[63:32] : mul_a_q[31:0];
		b_half = cnt_q[1] ? mul_b_q[63:32] : mul_b_q[31:0];
		pp     = a_half * b_half;
		case ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]})
			2'd0:    pp_ext = {64'b0, pp};
			2'd1:    pp_ext = {32'b0, pp, 32'b0};
			default: pp_ext = {pp, 64'b0};
		endcase
		sq_rem   = {rem_q[33:0], sq_q[65:64]};
		sq_trial = {1'b0, root_q, 2'b01};
		div_r    = {div_rem_q, div_num_q[DIVW-1]};
		div_ge   = (div_r >= {1'b0, div_den_q});
		// Density floored at 0.0001 and never zero.
		dens     = (e_q.density < DFLOOR_RAW) ? DFLOOR_RAW : e_q.density;
		if (dens == '0) begin
			dens = 32'd1;
		end
		rep_val  = 64'(33'(ONE_RAW - root_q)) * 64'd50;
		hr       = cfg.radius - root_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_nonempty) begin
						e_q <= q_dout;
						if (q_dout.center) begin
							sum_x_q <= '0;
							sum_y_q <= '0;
							st_q    <= ST_DONE;
						end else if (q_dout.skip) begin
							st_q <= ST_DONE;
						end else begin
							mul_a_q <= {32'b0, q_dout.adx};
							mul_b_q <= {32'b0, q_dout.adx};
							prod_q  <= '0;
							cnt_q   <= CW'(3);
							ret_q   <= ST_SQY;
							st_q    <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= prod_q + pp_ext;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q <= ret_q;
					end
				end
				ST_DIV: begin
					div_rem_q <= div_ge ? 33'(div_r - {1'b0, div_den_q}) : div_r[32:0];
					div_num_q <= {div_num_q[DIVW-2:0], div_ge};
					cnt_q     <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q <= ret_q;
					end
				end
				ST_SQY: begin
					sx_q    <= prod_q[63:0];
					mul_a_q <= {32'b0, e_q.ady};
					mul_b_q <= {32'b0, e_q.ady};
					prod_q  <= '0;
					cnt_q   <= CW'(3);
					ret_q   <= ST_SQRT0;
					st_q    <= ST_MUL;
				end
				ST_SQRT0: begin
					sq_q   <= {1'b0, 65'({1'b0, sx_q} + {1'b0, prod_q[63:0]})};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= CW'(32);
					st_q   <= ST_SQRT;
				end
				ST_SQRT: begin
					// Two radicand bits and one root bit per cycle.
					if (sq_rem >= sq_trial) begin
						rem_q  <= sq_rem - sq_trial;
						root_q <= {root_q[31:0], 1'b1};
					end else begin
						rem_q  <= sq_rem;
						root_q <= {root_q[31:0], 1'b0};
					end
					sq_q  <= {sq_q[63:0], 2'b00};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (root_q == '0 || root_q < EPS_RAW || root_q > {1'b0, cfg.radius}) begin
						st_q <= ST_DONE;
					end else begin
						mul_a_q <= {32'b0, hr};
						mul_b_q <= {32'b0, hr};
						prod_q  <= '0;
						cnt_q   <= CW'(3);
						ret_q   <= ST_GRAD;
						st_q    <= ST_MUL;
					end
				end
				ST_GRAD: begin
					mul_a_q <= {16'b0, cfg.grad_scale};
					mul_b_q <= sat_shr(prod_q, FRAC_BITS);
					prod_q  <= '0;
					cnt_q   <= CW'(3);
					ret_q   <= ST_DIVM;
					st_q    <= ST_MUL;
				end
				ST_DIVM: begin
					grad_q    <= sat_shr(prod_q, 48);
					div_num_q <= {e_q.mass, {FRAC_BITS{1'b0}}};
					div_den_q <= {1'b0, dens};
					div_rem_q <= '0;
					cnt_q     <= CW'(DIVW - 1);
					ret_q     <= ST_MA;
					st_q      <= ST_DIV;
				end
				ST_MA: begin
					mul_a_q <= {32'b0, e_q.pmag};
					mul_b_q <= 64'(div_num_q);
					prod_q  <= '0;
					cnt_q   <= CW'(3);
					ret_q   <= ST_MB;
					st_q    <= ST_MUL;
				end
				ST_MB: begin
					mul_a_q <= sat_shr(prod_q, FRAC_BITS);
					mul_b_q <= grad_q;
					prod_q  <= '0;
					cnt_q   <= CW'(3);
					ret_q   <= ST_DIVX;
					st_q    <= ST_MUL;
				end
				ST_DIVX: begin
					b_q       <= sat_shr(prod_q, FRAC_BITS);
					div_num_q <= {e_q.adx, {FRAC_BITS{1'b0}}};
					div_den_q <= root_q;
					div_rem_q <= '0;
					cnt_q     <= CW'(DIVW - 1);
					ret_q     <= ST_DIVY;
					st_q      <= ST_DIV;
				end
				ST_DIVY: begin
					ux_q      <= div_num_q[FRAC_BITS:0];
					div_num_q <= {e_q.ady, {FRAC_BITS{1'b0}}};
					div_den_q <= root_q;
					div_rem_q <= '0;
					cnt_q     <= CW'(DIVW - 1);
					ret_q     <= ST_PX;
					st_q      <= ST_DIV;
				end
				ST_PX: begin
					uy_q <= div_num_q[FRAC_BITS:0];
					if (e_q.pmag != '0) begin
						mul_a_q <= b_q;
						mul_b_q <= 64'(ux_q);
						prod_q  <= '0;
						cnt_q   <= CW'(3);
						ret_q   <= ST_PY;
						st_q    <= ST_MUL;
					end else begin
						st_q <= ST_REP;
					end
				end
				ST_PY: begin
					sum_x_q <= sat_add(sum_x_q, sat_shr(prod_q, FRAC_BITS), e_q.p_neg == e_q.dx_neg);
					mul_a_q <= b_q;
					mul_b_q <= 64'(uy_q);
					prod_q  <= '0;
					cnt_q   <= CW'(3);
					ret_q   <= ST_PYA;
					st_q    <= ST_MUL;
				end
				ST_PYA: begin
					sum_y_q <= sat_add(sum_y_q, sat_shr(prod_q, FRAC_BITS), e_q.p_neg == e_q.dy_neg);
					st_q    <= ST_REP;
				end
				ST_REP: begin
					// Soft repulsion only inside one unit of distance.
					if (root_q < ONE_RAW) begin
						mul_a_q <= rep_val;
						mul_b_q <= 64'(ux_q);
						prod_q  <= '0;
						cnt_q   <= CW'(3);
						ret_q   <= ST_RY;
						st_q    <= ST_MUL;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_RY: begin
					sum_x_q <= sat_add(sum_x_q, sat_shr(prod_q, FRAC_BITS), e_q.dx_neg);
					mul_a_q <= rep_val;
					mul_b_q <= 64'(uy_q);
					prod_q  <= '0;
					cnt_q   <= CW'(3);
					ret_q   <= ST_RYA;
					st_q    <= ST_MUL;
				end
				ST_RYA: begin
					sum_y_q <= sat_add(sum_y_q, sat_shr(prod_q, FRAC_BITS), e_q.dy_neg);
					st_q    <= ST_DONE;
				end
				ST_DONE: begin
					if (e_q.center || !e_q.last) begin
						st_q <= ST_IDLE;
					end else if (emit_now) begin
						out_q.force_x <= emit(sum_x_q);
						out_q.force_y <= emit(sum_y_q);
						st_q          <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/spfa_checker.sv =====
// Port-level checks of the SPH pressure force accumulator and their binding.
module spfa_checker import spfa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data,
	input logic      cfg_ready
);

	// A stalled result holds its value until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// Reset leaves no result pending.
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result pending right after reset");

	// Configuration writes are never back-pressured.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cfg_ready)
		else $error("configuration port not ready");

endmodule

bind sph_pressure_force_accumulate spfa_checker u_spfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);
